/* rtl/row_major_to_page_column_bitmap_unit_macros.svh */
// Assertion macros shared by the row-major to page/column bitmap RTL.
// Expects signals named clk and arst_n in the including module.
`ifndef ROW_MAJOR_TO_PAGE_COLUMN_BITMAP_UNIT_MACROS_SVH
`define ROW_MAJOR_TO_PAGE_COLUMN_BITMAP_UNIT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define RMPCB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked only outside reset.
`define RMPCB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rmpcb_pkg.sv */
// Package for the row-major to page/column bitmap unit.
// Holds fixed field widths and codes; no dependencies.
package rmpcb_pkg;

	// Pixel and stored-row geometry.
	localparam int unsigned PIX_W       = 8;
	localparam int unsigned STORED_ROWS = 7;
	localparam int unsigned STORE_W     = STORED_ROWS * PIX_W;
	localparam int unsigned GROUP_W     = STORE_W + PIX_W;

	// Result field widths.
	localparam int unsigned COL_W  = 7;
	localparam int unsigned PAGE_W = 3;

	// Stream widths.
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 24;

	// Row within a page that triggers the column output.
	localparam logic [2:0] LAST_ROW = 3'd7;
	// Last column of a group of eight.
	localparam logic [2:0] LAST_COL = 3'd7;

endpackage

/* rtl/rmpcb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the row store of the bitmap unit. DEPTH must be at least 2.
module rmpcb_ram #(
	parameter int unsigned WIDTH = 56,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port; a read of the same address in the same cycle returns old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holding its value while not enabled.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/row_major_to_page_column_bitmap_unit.sv */
// Row-major to page/column bitmap unit: transposes 8x8 pixel blocks for a page-mode LCD.
// Flow: an accepted byte is registered in stage 1; an eighth-row byte then waits there until
// stage 2 is free and loads it. Bytes of rows 0..6 do a read-modify-write of one store word and
// never wait in stage 1; an eighth-row byte yields eight column bytes, one per cycle while m_tready is high.
// Reset clears the counters and pipeline valid bits; the row store is not cleared and needs
// no clearing pass, since every entry is written before it is used.
module row_major_to_page_column_bitmap_unit #(
	parameter int unsigned FRAME_WIDTH  = 128,
	parameter int unsigned FRAME_HEIGHT = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [rmpcb_pkg::IN_TDATA_W-1:0]    s_tdata,  // [7:0] pixel_byte
	input  logic [0:0]                          s_tuser,  // [0] frame_start
	// Output stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rmpcb_pkg::OUT_TDATA_W-1:0]   m_tdata,  // [7:0] column_byte,
	                                                      // [14:8] column_index,
	                                                      // [17:15] page_index, rest zero
	output logic                                m_tlast,  // last_of_group
	output logic [0:0]                          m_tuser   // [0] last_of_frame
);
	import rmpcb_pkg::*;

	`include "row_major_to_page_column_bitmap_unit_macros.svh"

	localparam int unsigned BPR     = FRAME_WIDTH / 8;
	localparam int unsigned PAGES   = FRAME_HEIGHT / 8;
	localparam int unsigned BW      = (BPR > 1) ? $clog2(BPR) : 1;
	localparam int unsigned PW      = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int unsigned RAM_DEP = (BPR > 1) ? BPR : 2;

	// Frame position counters.
	logic [BW-1:0] byte_q;
	logic [2:0]    row_q;
	logic [PW-1:0] page_q;
	logic [BW-1:0] byte_eff;
	logic [2:0]    row_eff;
	logic [PW-1:0] page_eff;

	// Stage 1: store word read in flight.
	logic             s1_valid_s1;
	logic [BW-1:0]    s1_byte_s1;
	logic [2:0]       s1_row_s1;
	logic [PW-1:0]    s1_page_s1;
	logic [PIX_W-1:0] s1_pix_s1;

	// Forwarding of the write that overlapped the current read.
	logic               fwd_q;
	logic [STORE_W-1:0] fwd_data_q;

	// Stage 2: column emitter.
	logic               s2_valid_s2;
	logic [GROUP_W-1:0] s2_word_s2;
	logic [BW-1:0]      s2_byte_s2;
	logic [PW-1:0]      s2_page_s2;
	logic [2:0]         s2_col_s2;

	logic               in_acc;
	logic               out_acc;
	logic               s1_last_row;
	logic               s2_free;
	logic               s2_load;
	logic               s1_go;
	logic               wr_en;
	logic [STORE_W-1:0] ram_rdata;
	logic [STORE_W-1:0] rd_word;
	logic [STORE_W-1:0] merged;
	logic [PIX_W-1:0]   col_byte;
	logic [BW+2:0]      col_full;
	logic               frame_end;

	// Handshake and stage control.
	assign in_acc      = s_tvalid && s_tready;
	assign out_acc     = m_tvalid && m_tready;
	assign s1_last_row = (s1_row_s1 == LAST_ROW);
	assign s2_free     = !s2_valid_s2 || (m_tready && (s2_col_s2 == LAST_COL));
	assign s2_load     = s1_valid_s1 && s1_last_row && s2_free;
	assign s1_go       = s1_valid_s1 && (!s1_last_row || s2_free);
	assign s_tready    = !s1_valid_s1 || s1_go;
	assign wr_en       = s1_valid_s1 && !s1_last_row;

	// Position of the incoming byte, after an optional frame restart.
	assign byte_eff = s_tuser[0] ? '0 : byte_q;
	assign row_eff  = s_tuser[0] ? '0 : row_q;
	assign page_eff = s_tuser[0] ? '0 : page_q;

	// Counter advance: byte, then row, then page, wrapping at the end of the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
			row_q  <= '0;
			page_q <= '0;
		end else if (in_acc) begin
			if (byte_eff == BW'(BPR - 1)) begin
				byte_q <= '0;
				if (row_eff == LAST_ROW) begin
					row_q <= '0;
					if (page_eff == PW'(PAGES - 1)) begin
						page_q <= '0;
					end else begin
						page_q <= page_eff + 1'b1;
					end
				end else begin
					row_q  <= row_eff + 1'b1;
					page_q <= page_eff;
				end
			end else begin
				byte_q <= byte_eff + 1'b1;
				row_q  <= row_eff;
				page_q <= page_eff;
			end
		end
	end

	// Row store: one word per byte column, holding rows 0..6 of the current page.
	rmpcb_ram #(
		.WIDTH(STORE_W),
		.DEPTH(RAM_DEP)
	) u_row_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(s1_byte_s1),
		.wdata(merged),
		.re   (in_acc),
		.raddr(byte_eff),
		.rdata(ram_rdata)
	);

	// Merge the new byte into its row slot of the word read back.
	assign rd_word = fwd_q ? fwd_data_q : ram_rdata;
	always_comb begin
		merged = rd_word;
		for (int k = 0; k < int'(STORED_ROWS); k++) begin
			if (s1_row_s1 == 3'(k)) begin
				merged[k*PIX_W +: PIX_W] = s1_pix_s1;
			end
		end
	end

	// Stage 1 valid and forwarding flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			fwd_q       <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_valid_s1 <= 1'b1;
				fwd_q       <= wr_en && (s1_byte_s1 == byte_eff);
			end else if (s1_go) begin
				s1_valid_s1 <= 1'b0;
			end
		end
	end

	// Stage 1 payload and forwarded word.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_byte_s1 <= byte_eff;
			s1_row_s1  <= row_eff;
			s1_page_s1 <= page_eff;
			s1_pix_s1  <= s_tdata[PIX_W-1:0];
			fwd_data_q <= merged;
		end
	end

	// Stage 2 valid and column counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
			s2_col_s2   <= '0;
		end else if (s2_load) begin
			s2_valid_s2 <= 1'b1;
			s2_col_s2   <= '0;
		end else if (out_acc) begin
			if (s2_col_s2 == LAST_COL) begin
				s2_valid_s2 <= 1'b0;
			end else begin
				s2_col_s2 <= s2_col_s2 + 1'b1;
			end
		end
	end

	// Stage 2 payload: seven stored rows plus the eighth row.
	always_ff @(posedge clk) begin
		if (s2_load) begin
			s2_word_s2 <= {s1_pix_s1, rd_word};
			s2_byte_s2 <= s1_byte_s1;
			s2_page_s2 <= s1_page_s1;
		end
	end

	// Pick bit of the current column from each of the eight rows.
	always_comb begin
		col_byte = '0;
		for (int k = 0; k < 8; k++) begin
			col_byte[k] = s2_word_s2[k*PIX_W + int'(s2_col_s2)];
		end
	end

	assign col_full  = {s2_byte_s2, s2_col_s2};
	assign frame_end = (s2_col_s2 == LAST_COL) && (s2_byte_s2 == BW'(BPR - 1))
		&& (s2_page_s2 == PW'(PAGES - 1));

	// Output stream.
	assign m_tvalid = s2_valid_s2;
	assign m_tdata  = {{(OUT_TDATA_W - PIX_W - COL_W - PAGE_W){1'b0}},
		PAGE_W'(s2_page_s2), COL_W'(col_full), col_byte};
	assign m_tlast  = (s2_col_s2 == LAST_COL);
	assign m_tuser  = frame_end;

	// A stored-row request never waits in stage 1.
	`RMPCB_ASSERT_NOW(a_store_no_stall, s1_valid_s1 && !s1_last_row, s1_go, "store stalled")
	// The store is only written for rows 0..6.
	`RMPCB_ASSERT_NOW(a_write_row, wr_en, s1_valid_s1 && (s1_row_s1 != LAST_ROW), "bad write")
	// An overlapping write to the read address selects the forwarded word.
	`RMPCB_ASSERT_NEXT(a_fwd, in_acc && wr_en && (s1_byte_s1 == byte_eff), fwd_q, "no forward")
	// End of frame only falls on the last byte of a group.
	`RMPCB_ASSERT_NOW(a_frame_last, m_tvalid && m_tuser[0], m_tlast, "frame end mid group")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for row_major_to_page_column_bitmap_unit.
// Streams pixel bytes in frame order, predicts the column bytes of each 8x8 block, and checks
// every output request. Depends on rmpcb_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_top;
	import rmpcb_pkg::*;

	localparam int unsigned FRAME_WIDTH   = 128;
	localparam int unsigned FRAME_HEIGHT  = 64;
	localparam int unsigned BYTES_PER_ROW = FRAME_WIDTH / 8;
	localparam int unsigned PAGES         = FRAME_HEIGHT / 8;
	localparam int unsigned PAD_LSB       = PIX_W + COL_W + PAGE_W;

	// Stimulus shape.
	localparam int unsigned RANDOM_BYTES  = 408;
	localparam int unsigned ORDERED_BYTES = 300;
	localparam int unsigned DRAIN_AT      = 200;
	// Stretches with no idling, counted in requests on each side.
	localparam int unsigned SEND_QUIET_LO = 220;
	localparam int unsigned SEND_QUIET_HI = 340;
	localparam int unsigned RECV_QUIET_LO = 140;
	localparam int unsigned RECV_QUIET_HI = 240;
	// Long receiver hold-off.
	localparam int unsigned HOLD_AT       = 40;
	localparam int unsigned HOLD_LEN      = 400;
	localparam int unsigned TAIL_CYCLES   = 20;
	localparam int unsigned QUIET_LIMIT   = 5000;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             frame_start;
		logic             drain_first;
	} pixel_req_t;

	typedef struct {
		logic [PIX_W-1:0]  column_byte;
		logic [COL_W-1:0]  column_index;
		logic [PAGE_W-1:0] page_index;
		logic              last_of_group;
		logic              last_of_frame;
	} column_req_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;  // [7:0] pixel_byte
	logic [0:0]             s_tuser  = '0;  // [0] frame_start
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // [7:0] column_byte, [14:8] column_index,
	                                        // [17:15] page_index, rest zero
	logic                   m_tlast;        // last_of_group
	logic [0:0]             m_tuser;        // [0] last_of_frame

	pixel_req_t  pixel_q[$];
	column_req_t column_q[$];

	// Shadow of the unit: stored rows of the current page and the frame position.
	logic [PIX_W-1:0]  page_rows [0:STORED_ROWS-1][0:BYTES_PER_ROW-1];
	logic [3:0]        byte_pos = '0;
	logic [2:0]        row_pos  = '0;
	logic [PAGE_W-1:0] page_pos = '0;

	int unsigned errors       = 0;
	int unsigned bytes_sent   = 0;
	int unsigned columns_seen = 0;
	int unsigned quiet_cycles = 0;

	row_major_to_page_column_bitmap_unit #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input int unsigned got_v,
			input int unsigned want_v);
		$display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got_v, want_v);
		errors++;
	endtask

	// Take one pixel byte: store it, or on the eighth row of a page transpose the block.
	function automatic void transpose_byte(input logic [PIX_W-1:0] pix, input logic restart);
		column_req_t col;
		int          c;
		int          k;
		if (restart) begin
			byte_pos = '0;
			row_pos  = '0;
			page_pos = '0;
		end
		if (row_pos != LAST_ROW) begin
			page_rows[row_pos][byte_pos] = pix;
		end else begin
			for (c = 0; c < 8; c++) begin
				for (k = 0; k < STORED_ROWS; k++)
					col.column_byte[k] = page_rows[k][byte_pos][c];
				col.column_byte[7] = pix[c];
				col.column_index   = {byte_pos, 3'(c)};
				col.page_index     = page_pos;
				col.last_of_group  = (c == 7);
				col.last_of_frame  = (c == 7) && (byte_pos == BYTES_PER_ROW - 1) &&
					(page_pos == PAGES - 1);
				column_q.push_back(col);
			end
		end
		// Advance the frame position; the frame wraps after its last page.
		if (byte_pos == BYTES_PER_ROW - 1) begin
			byte_pos = '0;
			if (row_pos == 3'd7) begin
				row_pos  = '0;
				page_pos = (page_pos == PAGES - 1) ? '0 : page_pos + 1'b1;
			end else begin
				row_pos = row_pos + 1'b1;
			end
		end else begin
			byte_pos = byte_pos + 1'b1;
		end
	endfunction

	// Input driver: predicts each accepted request and offers the next one from the queue.
	always @(posedge clk or negedge arst_n) begin : pixel_driver
		pixel_req_t nxt;
		logic       offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				transpose_byte(s_tdata[PIX_W-1:0], s_tuser[0]);
				bytes_sent++;
			end
			if (!s_tvalid || s_tready) begin
				offer = (pixel_q.size() != 0);
				// A marked request waits until every column byte so far has arrived.
				if (offer && pixel_q[0].drain_first && column_q.size() != 0)
					offer = 1'b0;
				if (offer && !(bytes_sent >= SEND_QUIET_LO && bytes_sent < SEND_QUIET_HI) &&
						$urandom_range(0, 99) < 23)
					offer = 1'b0;
				if (offer) begin
					nxt = pixel_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.pixel;
					s_tuser  <= nxt.frame_start;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each accepted request and paces m_tready, with one long hold-off.
	always @(posedge clk or negedge arst_n) begin : column_monitor
		column_req_t want;
		int unsigned hold_left;
		logic        held;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left = 0;
			held      = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				columns_seen++;
				if (column_q.size() == 0) begin
					report_mismatch("unexpected column byte", m_tdata, 0);
				end else begin
					want = column_q.pop_front();
					if (m_tdata[PIX_W-1:0] != want.column_byte)
						report_mismatch("column_byte", m_tdata[PIX_W-1:0], want.column_byte);
					if (m_tdata[PIX_W +: COL_W] != want.column_index)
						report_mismatch("column_index", m_tdata[PIX_W +: COL_W],
							want.column_index);
					if (m_tdata[PIX_W + COL_W +: PAGE_W] != want.page_index)
						report_mismatch("page_index", m_tdata[PIX_W + COL_W +: PAGE_W],
							want.page_index);
					if (m_tdata[OUT_TDATA_W-1:PAD_LSB] != '0)
						report_mismatch("tdata padding", m_tdata[OUT_TDATA_W-1:PAD_LSB], 0);
					if (m_tlast != want.last_of_group)
						report_mismatch("last_of_group", m_tlast, want.last_of_group);
					if (m_tuser[0] != want.last_of_frame)
						report_mismatch("last_of_frame", m_tuser[0], want.last_of_frame);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (columns_seen == HOLD_AT && !held) begin
				held      = 1'b1;
				hold_left = HOLD_LEN;
				m_tready  <= 1'b0;
			end else if (!(columns_seen >= RECV_QUIET_LO && columns_seen < RECV_QUIET_HI) &&
					$urandom_range(0, 99) < 23) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run when no request moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Build the stimulus, release reset, then wait for the last column byte.
	initial begin : stimulus
		pixel_req_t  req;
		logic [7:0]  corner [0:7];
		int unsigned n;
		int unsigned pick;
		corner = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0};

		// Directed: field extremes and bit patterns, then a restart in the middle of a row.
		req.drain_first = 1'b0;
		for (n = 0; n < 8; n++) begin
			req.pixel       = corner[n];
			req.frame_start = (n == 0);
			pixel_q.push_back(req);
		end
		req.pixel       = 8'hFF;
		req.frame_start = 1'b1;
		pixel_q.push_back(req);
		for (n = 0; n < 4; n++) begin
			req.pixel       = corner[7 - n];
			req.frame_start = 1'b0;
			pixel_q.push_back(req);
		end

		// Random: an ordered run from a frame start, then bytes broken by occasional restarts.
		for (n = 0; n < RANDOM_BYTES; n++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				req.pixel = 8'h00;
			else if (pick == 1)
				req.pixel = 8'hFF;
			else
				req.pixel = 8'($urandom_range(0, 255));
			if (n == 0)
				req.frame_start = 1'b1;
			else if (n < ORDERED_BYTES)
				req.frame_start = 1'b0;
			else
				req.frame_start = ($urandom_range(0, 39) == 0);
			req.drain_first = (n == DRAIN_AT);
			pixel_q.push_back(req);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pixel_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (column_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (column_q.size() != 0)
			report_mismatch("column bytes never delivered", column_q.size(), 0);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/rmpcb_pkg.sv
rtl/rmpcb_ram.sv
rtl/row_major_to_page_column_bitmap_unit.sv
tb/tb_top.sv
